### rtl/round_robin_task_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RRTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define RRTS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RRTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)

`define RRTS_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/rrts_pkg.sv
package rrts_pkg;

    localparam int NUM_TASKS  = 8;
    localparam int TASK_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int TICK_W     = 32;
    localparam int OUT_TASK_W = 3;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SLEEP = 1'b1;

    localparam logic [TASK_W-1:0] IDLE_TASK  = '0;
    localparam logic [TASK_W-1:0] FIRST_TASK = TASK_W'(1);
    localparam logic [TASK_W-1:0] LAST_TASK  = TASK_W'(NUM_TASKS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_DONE
    } rrts_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [TASK_W-1:0] wr_addr;
        logic [TICK_W-1:0] wr_data;
        logic [TASK_W-1:0] rd_addr;
    } rrts_mem_req_t;

    typedef struct packed {
        logic [OUT_TASK_W-1:0] running_task;
        logic                  is_idle;
        logic [TICK_W-1:0]     tick_now;
    } rrts_result_t;

    function automatic logic [OUT_TASK_W-1:0] task_to_out(input logic [TASK_W-1:0] t);
        logic [TASK_W+OUT_TASK_W-1:0] ext;
        ext = {{OUT_TASK_W{1'b0}}, t};
        return ext[OUT_TASK_W-1:0];
    endfunction

    function automatic logic [TASK_W-1:0] next_task(input logic [TASK_W-1:0] t);
        return (t == LAST_TASK) ? IDLE_TASK : t + FIRST_TASK;
    endfunction

endpackage

### rtl/rrts_wake_mem.sv
module rrts_wake_mem
    import rrts_pkg::*;
(
    input  logic              aclk,
    input  rrts_mem_req_t     req,
    output logic [TICK_W-1:0] rd_data
);

    logic [TICK_W-1:0] mem [NUM_TASKS];
    logic [TICK_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/rrts_ctrl.sv
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_kind,
    input  logic [TICK_W-1:0] in_delay,
    output logic              in_ready,
    output rrts_mem_req_t     mem_req,
    input  logic [TICK_W-1:0] mem_rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output rrts_result_t      res
);

    rrts_state_t state_reg, state_next;

    logic [TICK_W-1:0]    count_reg, count_next;
    logic [TASK_W-1:0]    active_reg, active_next;
    logic [NUM_TASKS-1:0] blocked_reg, blocked_next;
    logic [TASK_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [TASK_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [TASK_W-1:0]    pick_idx_reg, pick_idx_next;

    logic              accept;
    logic [TASK_W-1:0] cand;
    logic              cand_ready;

    assign accept     = in_valid && in_ready;
    assign cand       = next_task(pick_idx_reg);
    assign cand_ready = !blocked_reg[cand];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_kind == KIND_TICK) begin
                        state_next = (NUM_TASKS > 1) ? ST_SCAN : ST_PICK;
                    end else if (active_reg != IDLE_TASK) begin
                        state_next = ST_PICK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_TASK) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (cand_ready) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);

        count_next     = count_reg;
        active_next    = active_reg;
        blocked_next   = blocked_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        pick_idx_next  = pick_idx_reg;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = active_reg;
        mem_req.wr_data = count_reg + in_delay;
        mem_req.rd_addr = scan_idx_reg;

        if (accept) begin
            pick_idx_next = active_reg;
            scan_idx_next = FIRST_TASK;
            if (in_kind == KIND_TICK) begin
                count_next = count_reg + TICK_W'(1);
            end else if (active_reg != IDLE_TASK) begin
                mem_req.wr_en            = 1'b1;
                blocked_next[active_reg] = 1'b1;
            end
        end

        if (state_reg == ST_SCAN) begin
            cmp_valid_next = 1'b1;
            cmp_idx_next   = scan_idx_reg;
            scan_idx_next  = scan_idx_reg + FIRST_TASK;
        end

        // The wake time read in the previous cycle is compared against the advanced count.
        if (cmp_valid_reg && blocked_reg[cmp_idx_reg] && (mem_rd_data <= count_reg)) begin
            blocked_next[cmp_idx_reg] = 1'b0;
        end

        if (state_reg == ST_PICK) begin
            pick_idx_next = cand;
            if (cand_ready) begin
                active_next = cand;
            end
        end

        blocked_next[0] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            active_reg    <= (NUM_TASKS > 1) ? FIRST_TASK : IDLE_TASK;
            blocked_reg   <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            blocked_reg   <= blocked_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        pick_idx_reg <= pick_idx_next;
    end

    assign res.running_task = task_to_out(active_reg);
    assign res.is_idle      = (active_reg == IDLE_TASK);
    assign res.tick_now     = count_reg;

endmodule

### rtl/round_robin_task_scheduler_unit.sv
// Round robin task scheduler with timed blocking.
// Input channel s_*: one item per event. s_tuser is the kind (timer tick or
// sleep request of the running task), s_tdata carries the sleep length in ticks.
// Output channel m_*: exactly one item per input item, in order. It reports the
// task chosen to run, whether that is the idle task, and the tick count.
// A tick reads the wake time of each of tasks 1 to NUM_TASKS - 1 in turn
// through the single read port of the wake time memory, waits for the last
// read to return, then walks the round robin order to the next ready task
// and loads the output register. A sleep request walks the round robin
// order and then loads the output register; a sleep request while the idle
// task runs skips the walk. One item is worked on at a time; the next is
// taken in the cycle after the result has moved into the output register.
// After reset the tick count is zero, task 1 runs and every task is ready.
// The wake time memory needs no clearing, since a read wake time is used only for blocked tasks.
// When the receiver stalls, the result waits in the output register and the
// block still takes and works one more item, then holds it until room frees.
`include "round_robin_task_scheduler_unit_defines.svh"

module round_robin_task_scheduler_unit
    import rrts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // delay_ticks[31:0]
    input  logic        s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // running_task[2:0], tick_now[34:3], zero[39:35]
    output logic        m_tuser    // is_idle[0]
);

    rrts_mem_req_t     mem_req;
    logic [TICK_W-1:0] mem_rd_data;
    logic              res_valid;
    logic              res_ready;
    rrts_result_t      res;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;
    logic              load;

    rrts_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_kind     (s_tuser),
        .in_delay    (s_tdata),
        .in_ready    (s_tready),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    rrts_wake_mem u_wake_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;
    assign load      = res_valid && res_ready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, res.tick_now, res.running_task};
            m_tuser_next  = res.is_idle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RRTS_ASSERT_IMP(a_ready_no_pending, aclk, aresetn, s_tready, !res_valid, "input ready while a result is pending")
    `RRTS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item taken before the first was finished")
    `RRTS_ASSERT_NXT(a_load_sets_valid, aclk, aresetn, load, m_tvalid, "result lost on its way to the output register")
    `RRTS_ASSERT_IMP(a_write_only_idle, aclk, aresetn, mem_req.wr_en, s_tready && !res_valid, "wake time written outside the idle state")

endmodule

### verif/round_robin_task_scheduler_unit_test.sv
`timescale 1ns / 1ps

module round_robin_task_scheduler_unit_test;
    import rrts_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SETTLE_CYCLES = 4 * NUM_TASKS + 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = KIND_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    round_robin_task_scheduler_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    logic [31:0]  model_tick;
    int unsigned  cur_task;
    bit           task_asleep [NUM_TASKS];
    logic [31:0]  wake_at     [NUM_TASKS];

    rrts_result_t pending_results[$];
    int           errors      = 0;
    int           cycle_count = 0;
    int           burst_left  = 1;
    int           hold_request = 0;
    int           hold_left   = 0;
    int           rx_mode     = 0;
    int           rx_cycle    = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items outstanding", $time, pending_results.size());
            $display("FAIL round_robin_task_scheduler_unit");
            $finish;
        end
    end

    function automatic void clear_scheduler();
        model_tick = '0;
        cur_task = 1 % NUM_TASKS;
        for (int i = 0; i < NUM_TASKS; i++) begin
            task_asleep[i] = 1'b0;
            wake_at[i] = '0;
        end
    endfunction

    function automatic void rotate_to_ready();
        int unsigned t;
        bit          found;
        t = cur_task;
        found = 1'b0;
        for (int n = 0; n < NUM_TASKS; n++) begin
            t = (t + 1) % NUM_TASKS;
            if (!task_asleep[t]) begin
                found = 1'b1;
                break;
            end
        end
        cur_task = found ? t : 0;
    endfunction

    function automatic rrts_result_t schedule_event(input logic kind, input logic [31:0] sleep_len);
        rrts_result_t res;
        if (kind == KIND_TICK) begin
            model_tick = model_tick + 32'd1;
            for (int i = 1; i < NUM_TASKS; i++) begin
                if (task_asleep[i] && wake_at[i] <= model_tick) begin
                    task_asleep[i] = 1'b0;
                end
            end
            rotate_to_ready();
        end else if (cur_task != 0) begin
            wake_at[cur_task] = model_tick + sleep_len;
            task_asleep[cur_task] = 1'b1;
            rotate_to_ready();
        end
        res.running_task = cur_task[OUT_TASK_W-1:0];
        res.is_idle = (cur_task == 0);
        res.tick_now = model_tick;
        return res;
    endfunction

    // The receiver changes its stall pattern now and then; a requested hold
    // keeps it from taking anything while the hold counts down.
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= (rx_cycle % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        rrts_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, running_task %0d tick_now %0d",
                         $time, m_tdata[2:0], m_tdata[34:3]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.running_task) begin
                    $display("%0t: running_task expected %0d actual %0d",
                             $time, want.running_task, m_tdata[2:0]);
                    errors++;
                end
                if (m_tuser !== want.is_idle) begin
                    $display("%0t: is_idle expected %0d actual %0d",
                             $time, want.is_idle, m_tuser);
                    errors++;
                end
                if (m_tdata[34:3] !== want.tick_now) begin
                    $display("%0t: tick_now expected %0d actual %0d",
                             $time, want.tick_now, m_tdata[34:3]);
                    errors++;
                end
                if (m_tdata[39:35] !== 5'd0) begin
                    $display("%0t: padding expected 0 actual %0h", $time, m_tdata[39:35]);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] sleep_len);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= sleep_len;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(schedule_event(kind, sleep_len));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_random_event();
        logic        kind;
        logic [31:0] sleep_len;
        int          pick;
        kind = ($urandom_range(0, 99) < 55) ? KIND_TICK : KIND_SLEEP;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            sleep_len = $urandom_range(0, 15);
        end else if (pick < 88) begin
            sleep_len = $urandom_range(16, 300);
        end else if (pick < 99) begin
            sleep_len = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        end else begin
            sleep_len = $urandom;
        end
        send_item(kind, sleep_len);
    endtask

    task automatic test_zero_and_wrapping_sleep();
        send_item(KIND_SLEEP, 32'd0);
        send_item(KIND_TICK, 32'd0);
        send_item(KIND_SLEEP, 32'hFFFF_FFFF);
        send_item(KIND_TICK, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_all_asleep_then_idle();
        for (int i = 1; i < NUM_TASKS; i++) begin
            send_item(KIND_SLEEP, 32'd5);
        end
        send_item(KIND_SLEEP, 32'h8000_0000);
        send_item(KIND_SLEEP, 32'd0);
        for (int i = 0; i < 6; i++) begin
            send_item(KIND_TICK, 32'h5555_AAAA);
        end
        wait_for_results();
    endtask

    task automatic test_sleep_length_extremes();
        send_item(KIND_SLEEP, 32'h8000_0000);
        send_item(KIND_SLEEP, 32'h7FFF_FFFF);
        send_item(KIND_SLEEP, 32'd1);
        send_item(KIND_TICK, 32'd0);
        send_item(KIND_TICK, 32'd0);
        wait_for_results();
    endtask

    task automatic test_random_events(input int count);
        for (int i = 0; i < count; i++) begin
            send_random_event();
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        hold_request = 300;
        for (int i = 0; i < 12; i++) begin
            send_random_event();
        end
        wait_for_results();
    endtask

    initial begin
        clear_scheduler();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_and_wrapping_sleep();
        test_all_asleep_then_idle();
        test_sleep_length_extremes();
        test_random_events(RANDOM_ITEMS / 3);
        test_output_backpressure();
        test_random_events(RANDOM_ITEMS - RANDOM_ITEMS / 3);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS round_robin_task_scheduler_unit");
        end else begin
            $display("FAIL round_robin_task_scheduler_unit");
        end
        $finish;
    end

endmodule
